// File: rtl/stfc_pkg.sv
`timescale 1ns / 1ps
package stfc_pkg;

    localparam int LINE_CHARS_DEF  = 16;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam int TEXT_BYTES = 32;
    localparam int TEXT_AW    = 5;

    localparam logic [5:0] POS_WAIT  = 6'd0;
    localparam logic [5:0] POS_TEXT  = 6'd32;
    localparam logic [5:0] POS_COUNT = 6'd33;
    localparam logic [5:0] POS_SUM   = 6'd34;

    localparam logic [7:0] BYTE_HEADER = 8'hFF;
    localparam logic [7:0] BYTE_FE     = 8'hFE;
    localparam logic [7:0] CHAR_ZERO   = 8'h00;
    localparam logic [7:0] CHAR_ONE    = 8'h01;
    localparam logic [7:0] TWO_ROWS    = 8'h01;
    localparam logic [5:0] SEC_LAST    = 6'd59;
    localparam logic [7:0] LIMIT_RESET = 8'd5;
    localparam logic [7:0] LIMIT_MIN   = 8'd1;
    localparam logic [7:0] COUNT_MAX   = 8'hFF;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic [1:0] KIND_CHAR  = 2'd0;
    localparam logic [1:0] KIND_REPLY = 2'd1;
    localparam logic [1:0] KIND_TMO   = 2'd2;

    typedef struct packed {
        logic       frame;
        logic       ok;
        logic       two_rows;
        logic       tmo;
        logic [7:0] minutes;
    } t_job;

    typedef struct packed {
        logic               en;
        logic [TEXT_AW-1:0] addr;
        logic [7:0]         data;
    } t_text_wr;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_CHAR,
        S_REPLY,
        S_TMO
    } t_back_state;

endpackage

// File: rtl/stfc_in_if.sv
`timescale 1ns / 1ps
interface stfc_in_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] rx_byte;
    logic [5:0] seconds;

    modport source (output valid, output op, output rx_byte, output seconds, input ready);
    modport sink (input valid, input op, input rx_byte, input seconds, output ready);
endinterface

// File: rtl/stfc_out_if.sv
`timescale 1ns / 1ps
interface stfc_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic       row;
    logic [3:0] column;
    logic [7:0] char_code;
    logic       frame_ok;
    logic [7:0] minutes;
    logic       last;

    modport source (output valid, output kind, output row, output column, output char_code,
                    output frame_ok, output minutes, output last, input ready);
    modport sink (input valid, input kind, input row, input column, input char_code,
                  input frame_ok, input minutes, input last, output ready);
endinterface

// File: rtl/serial_text_frame_checker_top.sv
`timescale 1ns / 1ps
// Results: an accepted item that causes results is pushed into the job queue as a job; the back
// end pops it and emits registered results, reading the text store in S_FETCH before each character.
// Throughput: 1 item per cycle while the job queue has room; after a good frame no item is
// taken until its text rows are out, since the back end reads the text store one entry per read.
// Reset: synchronous, active low; clears the frame, minute and queue state and sets the limit
// to 5. The text store is not cleared.
module serial_text_frame_checker_top import stfc_pkg::*; #(
    parameter int LINE_CHARS  = LINE_CHARS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    stfc_in_if.sink    i_in,
    stfc_out_if.source o_out,
    input  logic       i_cfg_wr_en,
    input  logic [7:0] i_cfg_wr_data
);

    logic     w_push;
    logic     w_pop;
    logic     w_full;
    logic     w_empty;
    logic     w_rows_done;
    t_job     w_job_in;
    t_job     w_job_out;
    t_text_wr w_text_wr;

    stfc_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in          (i_in),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_queue_full  (w_full),
        .i_rows_done   (w_rows_done),
        .o_push        (w_push),
        .o_job         (w_job_in),
        .o_text_wr     (w_text_wr)
    );

    stfc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job_in),
        .i_pop   (w_pop),
        .o_job   (w_job_out),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    stfc_back #(
        .LINE_CHARS (LINE_CHARS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_text_wr     (w_text_wr),
        .i_queue_empty (w_empty),
        .i_job         (w_job_out),
        .o_pop         (w_pop),
        .o_rows_done   (w_rows_done),
        .o_out         (o_out)
    );

endmodule

// File: rtl/stfc_front.sv
`timescale 1ns / 1ps
module stfc_front import stfc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    stfc_in_if.sink     i_in,
    input  logic        i_cfg_wr_en,
    input  logic [7:0]  i_cfg_wr_data,
    input  logic        i_queue_full,
    input  logic        i_rows_done,
    output logic        o_push,
    output t_job        o_job,
    output t_text_wr    o_text_wr
);

    logic [5:0] r_pos, n_pos;
    logic [7:0] r_sum, n_sum;
    logic       r_flag, n_flag;
    logic [7:0] r_count, n_count;
    logic       r_armed, n_armed;
    logic [7:0] r_limit, n_limit;
    logic       r_rows_pending, n_rows_pending;

    logic       w_accept;
    logic [7:0] w_limit_eff;
    logic [7:0] w_mapped;
    t_job       w_job;
    t_text_wr   w_wr;
    logic       w_push;

    assign i_in.ready  = !i_queue_full && !r_rows_pending;
    assign w_accept    = i_in.valid && i_in.ready;
    assign w_limit_eff = (r_limit == '0) ? LIMIT_MIN : r_limit;
    assign w_mapped    = (i_in.rx_byte == BYTE_HEADER) ? CHAR_ZERO :
                         (i_in.rx_byte == BYTE_FE)     ? CHAR_ONE  : i_in.rx_byte;

    always_comb begin
        n_pos   = r_pos;
        n_sum   = r_sum;
        n_flag  = r_flag;
        n_count = r_count;
        n_armed = r_armed;
        n_limit = i_cfg_wr_en ? i_cfg_wr_data : r_limit;
        w_job   = '0;
        w_wr    = '0;
        w_push  = 1'b0;
        if (w_accept) begin
            if (i_in.op == OP_TICK) begin
                if (i_in.seconds == SEC_LAST) begin
                    if (r_armed) begin
                        n_armed = 1'b0;
                        if (r_count != COUNT_MAX) begin
                            n_count = r_count + 8'd1;
                        end
                    end
                end else begin
                    n_armed = 1'b1;
                end
            end else begin
                if (r_pos == POS_WAIT) begin
                    if (i_in.rx_byte == BYTE_HEADER) begin
                        n_pos = 6'd1;
                        n_sum = '0;
                    end
                end else if (r_pos <= POS_TEXT) begin
                    w_wr.en   = 1'b1;
                    w_wr.addr = TEXT_AW'(r_pos - 6'd1);
                    w_wr.data = w_mapped;
                    n_sum     = r_sum + i_in.rx_byte;
                    n_pos     = r_pos + 6'd1;
                end else if (r_pos == POS_COUNT) begin
                    n_sum  = r_sum + i_in.rx_byte;
                    n_flag = (i_in.rx_byte == TWO_ROWS);
                    n_pos  = POS_SUM;
                end else if (r_pos == POS_SUM) begin
                    w_job.frame    = 1'b1;
                    w_job.ok       = (r_sum == i_in.rx_byte);
                    w_job.two_rows = r_flag;
                    n_count        = '0;
                    n_pos          = POS_WAIT;
                end else begin
                    n_pos = POS_WAIT;
                end
            end
            if (n_count >= w_limit_eff) begin
                w_job.tmo     = 1'b1;
                w_job.minutes = n_count;
                n_count       = '0;
            end
            w_push = w_job.frame || w_job.tmo;
        end
    end

    always_comb begin
        n_rows_pending = r_rows_pending;
        if (w_push && w_job.frame && w_job.ok) begin
            n_rows_pending = 1'b1;
        end else if (i_rows_done) begin
            n_rows_pending = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos          <= POS_WAIT;
            r_sum          <= '0;
            r_flag         <= 1'b0;
            r_count        <= '0;
            r_armed        <= 1'b0;
            r_limit        <= LIMIT_RESET;
            r_rows_pending <= 1'b0;
        end else begin
            r_pos          <= n_pos;
            r_sum          <= n_sum;
            r_flag         <= n_flag;
            r_count        <= n_count;
            r_armed        <= n_armed;
            r_limit        <= n_limit;
            r_rows_pending <= n_rows_pending;
        end
    end

    assign o_push    = w_push;
    assign o_job     = w_job;
    assign o_text_wr = w_wr;

`ifndef ASSERT_OFF
    a_pending_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rows_pending |-> !i_in.ready)
        else $error("item accepted while text rows still pending");
    a_frame_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && w_job.frame) |=> (r_count == '0))
        else $error("minute count not cleared by completed frame");
`endif

endmodule

// File: rtl/stfc_queue.sv
`timescale 1ns / 1ps
module stfc_queue import stfc_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output t_job o_job,
    output logic o_full,
    output logic o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_job   = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CW'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("queue push while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty))
        else $error("queue pop while empty");
`endif

endmodule

// File: rtl/stfc_back.sv
`timescale 1ns / 1ps
module stfc_back import stfc_pkg::*; #(
    parameter int LINE_CHARS = LINE_CHARS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_text_wr  i_text_wr,
    input  logic      i_queue_empty,
    input  t_job      i_job,
    output logic      o_pop,
    output logic      o_rows_done,
    stfc_out_if.source o_out
);

    localparam int COL_W   = $clog2(LINE_CHARS + 1);
    localparam int IDX_RAW = $clog2(2 * LINE_CHARS + 1);
    localparam int IDX_W   = (IDX_RAW > TEXT_AW + 1) ? IDX_RAW : TEXT_AW + 1;
    localparam bit ROW1_FITS = (LINE_CHARS < TEXT_BYTES);

    t_back_state r_state, n_state;
    t_job        r_job, n_job;
    logic        r_row, n_row;
    logic [COL_W-1:0] r_col, n_col;
    logic [7:0]  r_mem [TEXT_BYTES];
    logic [7:0]  r_rd_data;

    logic        r_out_valid, n_out_valid;
    logic [1:0]  r_kind, n_kind;
    logic        r_orow, n_orow;
    logic [3:0]  r_column, n_column;
    logic [7:0]  r_char, n_char;
    logic        r_ok, n_ok;
    logic [7:0]  r_minutes, n_minutes;
    logic        r_last, n_last;

    logic             w_ld;
    logic [IDX_W-1:0] w_idx;
    logic             w_row_end;
    logic             w_next_row;

    assign w_ld       = !r_out_valid || o_out.ready;
    assign w_idx      = r_row ? (IDX_W'(LINE_CHARS) + IDX_W'(r_col)) : IDX_W'(r_col);
    assign w_row_end  = (r_col == COL_W'(LINE_CHARS - 1)) || (w_idx == IDX_W'(TEXT_BYTES - 1));
    assign w_next_row = !r_row && r_job.two_rows && ROW1_FITS;

    always_ff @(posedge i_clk) begin
        if (i_text_wr.en) begin
            r_mem[i_text_wr.addr] <= i_text_wr.data;
        end
        r_rd_data <= r_mem[w_idx[TEXT_AW-1:0]];
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (!i_queue_empty) begin
                    if (i_job.frame && i_job.ok) begin
                        n_state = S_FETCH;
                    end else if (i_job.frame) begin
                        n_state = S_REPLY;
                    end else begin
                        n_state = S_TMO;
                    end
                end
            end
            S_FETCH: n_state = S_CHAR;
            S_CHAR: begin
                if (w_ld) begin
                    n_state = (w_row_end && !w_next_row) ? S_REPLY : S_FETCH;
                end
            end
            S_REPLY: begin
                if (w_ld) begin
                    n_state = r_job.tmo ? S_TMO : S_IDLE;
                end
            end
            S_TMO: begin
                if (w_ld) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_job       = r_job;
        n_row       = r_row;
        n_col       = r_col;
        n_out_valid = r_out_valid && !o_out.ready;
        n_kind      = r_kind;
        n_orow      = r_orow;
        n_column    = r_column;
        n_char      = r_char;
        n_ok        = r_ok;
        n_minutes   = r_minutes;
        n_last      = r_last;
        o_pop       = 1'b0;
        o_rows_done = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (!i_queue_empty) begin
                    o_pop = 1'b1;
                    n_job = i_job;
                    n_row = 1'b0;
                    n_col = '0;
                end
            end
            S_CHAR: begin
                if (w_ld) begin
                    n_out_valid = 1'b1;
                    n_kind      = KIND_CHAR;
                    n_orow      = r_row;
                    n_column    = 4'(r_col);
                    n_char      = r_rd_data;
                    n_ok        = 1'b0;
                    n_minutes   = '0;
                    n_last      = 1'b0;
                    if (!w_row_end) begin
                        n_col = r_col + COL_W'(1);
                    end else if (w_next_row) begin
                        n_row = 1'b1;
                        n_col = '0;
                    end else begin
                        o_rows_done = 1'b1;
                    end
                end
            end
            S_REPLY: begin
                if (w_ld) begin
                    n_out_valid = 1'b1;
                    n_kind      = KIND_REPLY;
                    n_orow      = 1'b0;
                    n_column    = '0;
                    n_char      = '0;
                    n_ok        = r_job.ok;
                    n_minutes   = '0;
                    n_last      = !r_job.tmo;
                end
            end
            S_TMO: begin
                if (w_ld) begin
                    n_out_valid = 1'b1;
                    n_kind      = KIND_TMO;
                    n_orow      = 1'b0;
                    n_column    = '0;
                    n_char      = '0;
                    n_ok        = 1'b0;
                    n_minutes   = r_job.minutes;
                    n_last      = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job     <= n_job;
        r_row     <= n_row;
        r_col     <= n_col;
        r_kind    <= n_kind;
        r_orow    <= n_orow;
        r_column  <= n_column;
        r_char    <= n_char;
        r_ok      <= n_ok;
        r_minutes <= n_minutes;
        r_last    <= n_last;
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.kind      = r_kind;
    assign o_out.row       = r_orow;
    assign o_out.column    = r_column;
    assign o_out.char_code = r_char;
    assign o_out.frame_ok  = r_ok;
    assign o_out.minutes   = r_minutes;
    assign o_out.last      = r_last;

`ifndef ASSERT_OFF
    a_char_after_fetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHAR) |-> ($past(r_state) == S_FETCH || $past(r_state) == S_CHAR))
        else $error("character emitted without a store read");
    a_tmo_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_kind == KIND_TMO || r_kind == KIND_CHAR))
            |-> (r_last == (r_kind == KIND_TMO)))
        else $error("wrong last flag on result");
`endif

endmodule
